[rtl/fdsn_pkg.sv]
// shared types and constants for the half-precision dot product and norms block
package fdsn_pkg;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF   = 32'h7F80_0000;

   // widened half-precision operand: a 22-bit product mantissa, a power of two and flags
   typedef struct packed {
      logic        sign;
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic [21:0] mant;   // product of two 11-bit significands
      logic [6:0]  expo;   // biased: value = mant * 2^(expo - 50)
   } prod_type;

   typedef struct packed {
      logic [15:0] left_element;
      logic [15:0] right_element;
      logic        final_element;
   } req_type;

   typedef struct packed {
      logic [31:0] inner_product;
      logic [31:0] left_square_norm;
      logic [31:0] right_square_norm;
   } rsp_type;

endpackage

[rtl/fdsn_stream_if.sv]
// valid/ready channel carrying one payload
interface fdsn_stream_if #(
   parameter int Width = 1
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/fdsn_mult.sv]
// exact product of two binary16 values in an unnormalised wide form
module fdsn_mult (
   input  logic [15:0]       a_in,
   input  logic [15:0]       b_in,
   output fdsn_pkg::prod_type prod
);
   logic [4:0]  ea, eb;
   logic [10:0] ma, mb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   always_comb begin
      ea = a_in[14:10];
      eb = b_in[14:10];
      ma = {(ea != 5'd0), a_in[9:0]};
      mb = {(eb != 5'd0), b_in[9:0]};
      a_nan  = (ea == 5'd31) && (a_in[9:0] != 10'd0);
      b_nan  = (eb == 5'd31) && (b_in[9:0] != 10'd0);
      a_inf  = (ea == 5'd31) && (a_in[9:0] == 10'd0);
      b_inf  = (eb == 5'd31) && (b_in[9:0] == 10'd0);
      a_zero = (a_in[14:0] == 15'd0);
      b_zero = (b_in[14:0] == 15'd0);
      prod.sign    = a_in[15] ^ b_in[15];
      prod.is_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      prod.is_inf  = a_inf || b_inf;
      prod.is_zero = a_zero || b_zero;
      prod.mant    = {11'd0, ma} * {11'd0, mb};
      // subnormal halves use exponent 1
      prod.expo    = 7'({2'd0, ((ea == 5'd0) ? 5'd1 : ea)}) +
                     7'({2'd0, ((eb == 5'd0) ? 5'd1 : eb)});
   end
endmodule

[rtl/fdsn_fma_add.sv]
// adds an exact product to a binary32 accumulator with one round to nearest even
module fdsn_fma_add (
   input  logic [31:0]        acc_in,
   input  fdsn_pkg::prod_type prod,
   output logic [31:0]        sum_out
);
   // fixed point: lsb weight 2^-200, covers product (>=2^-48) and accumulator (>=2^-149)
   localparam int FW = 360;

   logic          c_sign, c_nan, c_inf, c_zero;
   logic [7:0]    c_exp;
   logic [23:0]   c_mant;
   logic [FW-1:0] c_fix, p_fix, mag;
   logic          s_sign;
   logic [8:0]    lead;
   logic [9:0]    e_unb;
   logic [FW-1:0] norm;
   logic [24:0]   kept;
   logic          g, st;
   logic [8:0]    shamt;
   logic [9:0]    bexp;
   logic [24:0]   rnd;
   logic [9:0]    fexp;

   always_comb begin
      c_sign = acc_in[31];
      c_exp  = acc_in[30:23];
      c_nan  = (c_exp == 8'hFF) && (acc_in[22:0] != 23'd0);
      c_inf  = (c_exp == 8'hFF) && (acc_in[22:0] == 23'd0);
      c_zero = (acc_in[30:0] == 31'd0);
      c_mant = {(c_exp != 8'd0), acc_in[22:0]};
      // accumulator value = c_mant * 2^(e-150), e>=1; fixed shift = e-150+200
      c_fix = FW'(c_mant) << (((c_exp == 8'd0) ? 9'd1 : {1'b0, c_exp}) + 9'd50);
      // product = mant * 2^(expo-50); shift = expo-50+200
      p_fix = FW'(prod.mant) << ({2'd0, prod.expo} + 9'd150);
      s_sign = 1'b0;
      mag    = '0;
      if (prod.sign == c_sign) begin
         mag = c_fix + p_fix;
         s_sign = c_sign;
      end else if (c_fix >= p_fix) begin
         mag = c_fix - p_fix;
         s_sign = c_sign;
      end else begin
         mag = p_fix - c_fix;
         s_sign = prod.sign;
      end
      if (mag == '0) s_sign = c_sign & prod.sign;
      lead = '0;
      for (int i = 0; i < FW; i++) if (mag[i]) lead = 9'(i);
      // binary32 biased exponent of leading bit: lead - 200 + 127
      e_unb = {1'b0, lead} - 10'd73;
      if (lead < 9'd74) begin
         bexp  = 10'd0;
         shamt = 9'd51;          // subnormal: lsb at 2^-149 -> fixed bit 51
      end else begin
         bexp  = e_unb;
         shamt = lead - 9'd23;
      end
      norm = mag >> shamt;
      kept = {1'b0, norm[23:0]};
      g    = (shamt == 9'd0) ? 1'b0 : mag[shamt - 9'd1];
      st   = 1'b0;
      for (int i = 0; i < FW; i++) if ((9'(i) + 9'd1) < shamt && mag[i]) st = 1'b1;
      rnd  = kept + 25'((g && (st || kept[0])) ? 1 : 0);
      fexp = (bexp == 10'd0) ? 10'(rnd[23]) : bexp;
      if (rnd[24]) begin
         rnd  = rnd >> 1;
         fexp = fexp + 10'd1;
      end
      if (prod.is_nan || c_nan || (prod.is_inf && c_inf && (prod.sign != c_sign)))
         sum_out = fdsn_pkg::CANON_NAN;
      else if (prod.is_inf)
         sum_out = {prod.sign, fdsn_pkg::POS_INF[30:0]};
      else if (c_inf)
         sum_out = acc_in;
      else if (mag == '0 || (prod.is_zero && c_zero))
         sum_out = {s_sign, 31'd0};
      else if (fexp >= 10'd255)
         sum_out = {s_sign, fdsn_pkg::POS_INF[30:0]};
      else
         sum_out = {s_sign, fexp[7:0], rnd[22:0]};
   end
endmodule

[rtl/fp16_dot_and_square_norms.sv]
// top level: three fused accumulators and a result register
// the result is registered on the clock edge that accepts the final request
// throughput: one request per cycle unless the output stalls, set by the combinational add-and-round path
// a result waiting in the output register holds the input back only if not taken
// reset: synchronous, clears the accumulators to positive zero and empties the output
module fp16_dot_and_square_norms (
   input  logic              clock,
   input  logic              reset,
   fdsn_stream_if.sink       req,
   fdsn_stream_if.source     rsp
);
   fdsn_pkg::req_type  r;
   fdsn_pkg::prod_type p_lr, p_ll, p_rr;
   logic [31:0] ps_ff, ls_ff, rs_ff, ps_sum, ls_sum, rs_sum;
   logic        out_valid_ff;
   logic        out_valid_in;
   fdsn_pkg::rsp_type out_ff;
   logic        take;

   assign r = req.data;
   assign req.ready = !out_valid_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
   assign out_valid_in = (take && r.final_element) || (out_valid_ff && !rsp.ready);

   fdsn_mult u_lr (.a_in(r.left_element),  .b_in(r.right_element), .prod(p_lr));
   fdsn_mult u_ll (.a_in(r.left_element),  .b_in(r.left_element),  .prod(p_ll));
   fdsn_mult u_rr (.a_in(r.right_element), .b_in(r.right_element), .prod(p_rr));
   fdsn_fma_add u_ps (.acc_in(ps_ff), .prod(p_lr), .sum_out(ps_sum));
   fdsn_fma_add u_ls (.acc_in(ls_ff), .prod(p_ll), .sum_out(ls_sum));
   fdsn_fma_add u_rs (.acc_in(rs_ff), .prod(p_rr), .sum_out(rs_sum));

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= '0;
         ls_ff <= '0;
         rs_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            if (r.final_element) begin
               ps_ff <= '0;
               ls_ff <= '0;
               rs_ff <= '0;
               out_ff <= '{inner_product: ps_sum, left_square_norm: ls_sum,
                           right_square_norm: rs_sum};
            end else begin
               ps_ff <= ps_sum;
               ls_ff <= ls_sum;
               rs_ff <= rs_sum;
            end
         end
      end
   end
endmodule

[bench/fp16_dot_and_square_norms_tb.sv]
// self-checking bench for the half-precision dot product and squared norms block
`timescale 1ns / 100ps

module fp16_dot_and_square_norms_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdsn_stream_if #(.Width($bits(fdsn_pkg::req_type))) req_ch ();
   fdsn_stream_if #(.Width($bits(fdsn_pkg::rsp_type))) rsp_ch ();

   fp16_dot_and_square_norms dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: running binary32 sums
   logic [31:0] dot_sum, left_sum, right_sum;
   fdsn_pkg::rsp_type sums_due[$];
   int          error_count = 0;
   int          pairs_sent = 0;
   int          vectors_sent = 0;
   int          sums_checked = 0;
   int          burst_left = 0;
   int          hold_off = 0;
   int          stall_phase = 0;
   bit          stall_busy = 1'b0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic real half_to_real(logic [15:0] h);
      real v;
      if (h[14:10] == 5'h1F)
         return $bitstoreal({h[15], 11'h7FF, (h[9:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0});
      if (h[14:10] == 0)
         v = real'(h[9:0]) * $bitstoreal(64'(1023 - 24) << 52);
      else
         v = real'({1'b1, h[9:0]}) * $bitstoreal(64'(1023 - 25 + h[14:10]) << 52);
      return h[15] ? -v : v;
   endfunction

   function automatic real single_to_real(logic [31:0] x);
      real v;
      if (x[30:23] == 8'hFF)
         return $bitstoreal({x[31], 11'h7FF, (x[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0});
      if (x[30:23] == 0)
         v = real'(x[22:0]) * $bitstoreal(64'(1023 - 149) << 52);
      else
         v = $bitstoreal({1'b0, 11'(x[30:23] - 127 + 1023), x[22:0], 29'b0});
      return x[31] ? -v : v;
   endfunction

   // round a double bit pattern to binary32, nearest even, subnormals kept
   function automatic logic [31:0] narrow_to_single(logic [63:0] sb);
      int          ex, sh;
      logic [63:0] m, kept, rem, half, mag;
      if (sb[62:52] == 0)
         return {sb[63], 31'b0};
      ex = int'(sb[62:52]) - 1023;
      m  = {11'b0, 1'b1, sb[51:0]};
      sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
      if (sh > 63)
         sh = 63;
      kept = m >> sh;
      rem  = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0]))
         kept = kept + 1;
      if (ex >= -126)
         mag = (64'(ex + 127) << 23) + kept - (64'd1 << 23);
      else
         mag = kept;
      if (mag >= 64'h7F80_0000)
         mag = 64'h7F80_0000;
      return {sb[63], mag[30:0]};
   endfunction

   // acc + p with one rounding: exact double sum error, round to odd, then narrow
   function automatic logic [31:0] fused_accumulate(logic [31:0] acc, real p);
      real         c, s, bb, err;
      logic [63:0] sb;
      c  = single_to_real(acc);
      s  = p + c;
      sb = $realtobits(s);
      if (sb[62:52] == 11'h7FF)
         return (sb[51:0] != 0) ? fdsn_pkg::CANON_NAN : {sb[63], fdsn_pkg::POS_INF[30:0]};
      bb  = s - p;
      err = (p - (s - bb)) + (c - bb);
      if (err != 0.0 && sb[0] == 1'b0) begin
         if ((err > 0.0) == (s > 0.0))
            sb = sb + 1;
         else
            sb = sb - 1;
      end
      return narrow_to_single(sb);
   endfunction

   task automatic accumulate_pair(fdsn_pkg::req_type r);
      real a, b;
      a = half_to_real(r.left_element);
      b = half_to_real(r.right_element);
      dot_sum   = fused_accumulate(dot_sum, a * b);
      left_sum  = fused_accumulate(left_sum, a * a);
      right_sum = fused_accumulate(right_sum, b * b);
      if (r.final_element) begin
         sums_due.push_back('{dot_sum, left_sum, right_sum});
         dot_sum   = '0;
         left_sum  = '0;
         right_sum = '0;
         vectors_sent++;
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // sends one pair; bursts of random length, mostly separated by random gaps
   task automatic send_pair(logic [15:0] l, logic [15:0] r, logic f);
      fdsn_pkg::req_type item;
      item = '{l, r, f};
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(posedge clock); while (!req_ch.ready);
      pairs_sent++;
      accumulate_pair(item);
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_half();
      logic [15:0] h;
      h = 16'($urandom);
      // keep most elements finite so sums stay meaningful
      if ($urandom_range(0, 19) != 0 && h[14:10] == 5'h1F)
         h[14:10] = 5'($urandom_range(0, 30));
      return h;
   endfunction

   // receiver: alternating free and stalling phases, plus an occasional long hold-off
   always @(posedge clock) begin
      fdsn_pkg::rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (sums_due.size() == 0) begin
            report_mismatch("unexpected result", got.inner_product, 32'h0);
         end else begin
            want = sums_due.pop_front();
            if (got.inner_product !== want.inner_product)
               report_mismatch("inner_product", got.inner_product, want.inner_product);
            if (got.left_square_norm !== want.left_square_norm)
               report_mismatch("left_square_norm", got.left_square_norm, want.left_square_norm);
            if (got.right_square_norm !== want.right_square_norm)
               report_mismatch("right_square_norm", got.right_square_norm,
                               want.right_square_norm);
            sums_checked++;
         end
      end
      if (stall_phase == 0) begin
         stall_phase = $urandom_range(30, 150);
         stall_busy  = ~stall_busy;
      end
      stall_phase--;
      if (hold_off > 0) begin
         hold_off--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_busy)
         rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      else
         rsp_ch.ready <= 1'b1;
   end

   task automatic test_signed_zeros();
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'h8000, 16'h0000, 1'b1);
      send_pair(16'h8000, 16'h8000, 1'b0);
      send_pair(16'h0000, 16'h8000, 1'b1);
   endtask

   task automatic test_specials();
      send_pair(16'h7C00, 16'h3C00, 1'b1);   // infinity times one
      send_pair(16'h7C00, 16'h0000, 1'b1);   // infinity times zero
      send_pair(16'h7C00, 16'h3C00, 1'b0);   // opposite infinities in the product sum
      send_pair(16'hFC00, 16'h3C00, 1'b1);
      send_pair(16'h7E00, 16'h3C00, 1'b1);   // quiet nan operand
      send_pair(16'hFD55, 16'h4000, 1'b0);   // signalling nan, then ordinary element
      send_pair(16'h3C00, 16'h3C00, 1'b1);
   endtask

   task automatic test_extremes();
      send_pair(16'h7BFF, 16'hFBFF, 1'b0);   // largest finite
      send_pair(16'h7BFF, 16'h7BFF, 1'b1);
      send_pair(16'h0001, 16'h8001, 1'b0);   // smallest subnormal
      send_pair(16'h03FF, 16'h0001, 1'b1);
      send_pair(16'h0400, 16'h83FF, 1'b1);
      send_pair(16'hFFFF, 16'h0000, 1'b0);
      send_pair(16'h5555, 16'hAAAA, 1'b1);
   endtask

   task automatic random_vector(int max_len);
      int len;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++)
         send_pair(random_half(), random_half(), i == len - 1);
   endtask

   task automatic test_random_vectors(int pair_budget);
      int start;
      start = pairs_sent;
      while (pairs_sent - start < pair_budget)
         random_vector(($urandom_range(0, 3) == 0) ? 40 : 6);
   endtask

   task automatic test_backpressure();
      // results pile up behind a long stall while the sender keeps offering
      hold_off = 300;
      for (int i = 0; i < 40; i++)
         send_pair(random_half(), random_half(), 1'b1);
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      while (sums_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (5) @(posedge clock);
   endtask

   initial begin
      dot_sum   = '0;
      left_sum  = '0;
      right_sum = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_signed_zeros();
      test_specials();
      test_extremes();
      test_random_vectors(400);
      test_backpressure();
      test_random_vectors(400);
      stop_sending();
      drain_results();
      $display("sent %0d element pairs forming %0d vectors", pairs_sent, vectors_sent);
      $display("checked %0d sum triples incl. nan, infinity, subnormal and stall cases",
               sums_checked);
      if (error_count == 0 && sums_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $realtime);
      $display("Regression FAIL");
      $finish;
   end

endmodule
